// File: rtl/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
package bba_pkg;

    // Field widths of the transaction ports
    localparam int IDX_W = 10;
    localparam int OUT_W = 11;
    localparam int CFG_W = 11;

    // Bitmap word geometry: one memory word holds this many block bits
    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;

    // Defaults
    localparam int MAX_BLOCKS_DEF = 1024;
    localparam int BC_RESET       = 1024;

    typedef enum logic [1:0] {
        OP_CHECK   = 2'd0,
        OP_CLAIM   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_FIND    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_CONFLICT = 2'd2,
        ST_NOFREE   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_ACCESS,
        S_SCAN
    } state_t;

    // Result of a free-bit search inside one bitmap word
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] pos;
    } scan_res_t;

endpackage

// File: rtl/bitmap_block_allocator_top.sv
// Bitmap block allocator: control sequencer, counters and result registers.
// An out-of-range index is answered straight from idle; check, release and a claim off
// the hint take one map access, and find and a claim of the hint block then scan 64-bit
// map words (up to ceil(block_count/64) of them). One transaction at a time, the next
// accepted in the done cycle. Reset and each block_count write clear the map with busy
// high; done is a one-cycle strobe, never stalled.
module bitmap_block_allocator_top #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  operation,
    input  logic [bba_pkg::IDX_W-1:0]   block_index,
    input  logic                        block_count_wr,
    input  logic [bba_pkg::CFG_W-1:0]   block_count_data,
    output logic                        done,
    output logic [1:0]                  status,
    output logic [bba_pkg::OUT_W-1:0]   found_block,
    output logic [bba_pkg::OUT_W-1:0]   free_total,
    output logic [bba_pkg::OUT_W-1:0]   first_free_hint
);

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int WORDS = (MAX_BLOCKS + bba_pkg::WORD_BITS - 1) / bba_pkg::WORD_BITS;
    localparam int WA    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW    = bba_pkg::BIT_W;
    localparam int WB    = bba_pkg::WORD_BITS;
    localparam logic [CNT_W-1:0] MAX_VAL = CNT_W'(MAX_BLOCKS);
    localparam logic [CNT_W-1:0] BC_INIT =
        CNT_W'((bba_pkg::BC_RESET > MAX_BLOCKS) ? MAX_BLOCKS : bba_pkg::BC_RESET);

    bba_pkg::state_t  state_reg, state_next;
    bba_pkg::op_t     op_reg, op_next;
    bba_pkg::status_t status_reg, status_next;
    logic [bba_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] bc_reg, bc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] hint_reg, hint_next;
    logic [CNT_W-1:0] found_reg, found_next;
    logic [WA-1:0]    chk_addr_reg, chk_addr_next;
    logic [WA-1:0]    clr_addr_reg, clr_addr_next;
    logic [BW-1:0]    low_bit_reg, low_bit_next;
    logic             done_reg, done_next;

    logic             mem_we;
    logic [WA-1:0]    mem_waddr, mem_raddr;
    logic [WB-1:0]    mem_wdata, mem_rdata;

    logic [BW:0]      scan_limit;
    bba_pkg::scan_res_t scan_res;

    logic [31:0] idx_in_x, idx_x, bc_x, base_x, rem_x, pos_x, next_x, cfg_x;
    logic [31:0] cnt_x, hint_x, found_x;
    logic [CNT_W-1:0] bc_sat;
    logic [WB-1:0]    bit_mask;
    logic             bit_used;

    // Bitmap storage
    bba_map_ram #(
        .WORDS (WORDS),
        .WA    (WA)
    ) u_map (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Free-bit search in the word just read
    bba_word_scan u_scan (
        .word    (mem_rdata),
        .low_bit (low_bit_reg),
        .limit   (scan_limit),
        .res     (scan_res)
    );

    // Wide views of the narrow registers for comparisons
    assign idx_in_x = 32'(block_index);
    assign idx_x    = 32'(idx_reg);
    assign bc_x     = 32'(bc_reg);
    assign base_x   = 32'(chk_addr_reg) << BW;
    assign rem_x    = bc_x - base_x;
    assign pos_x    = base_x + 32'(scan_res.pos);
    assign next_x   = idx_x + 32'd1;
    assign cfg_x    = 32'(block_count_data);
    assign bc_sat   = (cfg_x > 32'(MAX_BLOCKS)) ? MAX_VAL : CNT_W'(cfg_x);
    assign bit_mask = WB'(1) << idx_reg[BW-1:0];
    assign bit_used = mem_rdata[idx_reg[BW-1:0]];

    // Number of bits of the current word below block_count
    assign scan_limit = (rem_x >= 32'(WB)) ? (BW + 1)'(WB) : (BW + 1)'(rem_x);

    // State and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bba_pkg::S_CLEAR;
            clr_addr_reg <= '0;
            bc_reg       <= BC_INIT;
            cnt_reg      <= BC_INIT;
            hint_reg     <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            bc_reg       <= bc_next;
            cnt_reg      <= cnt_next;
            hint_reg     <= hint_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        chk_addr_reg <= chk_addr_next;
        low_bit_reg  <= low_bit_next;
    end

    // Sequencer: next state, map accesses and result
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        idx_next      = idx_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        bc_next       = bc_reg;
        cnt_next      = cnt_reg;
        hint_next     = hint_reg;
        chk_addr_next = chk_addr_reg;
        clr_addr_next = clr_addr_reg;
        low_bit_next  = low_bit_reg;
        done_next     = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = WA'(idx_x >> BW);
        mem_wdata     = mem_rdata;
        mem_raddr     = chk_addr_reg;

        case (state_reg)
            bba_pkg::S_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + WA'(1);
                if (clr_addr_reg == WA'(WORDS - 1))
                begin
                    state_next = bba_pkg::S_IDLE;
                end
            end

            bba_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op_next  = bba_pkg::op_t'(operation);
                    idx_next = block_index;
                    if (idx_in_x >= bc_x)
                    begin
                        done_next   = 1'b1;
                        status_next = bba_pkg::ST_RANGE;
                        found_next  = MAX_VAL;
                    end
                    else
                    begin
                        // Read the word holding the addressed block
                        mem_raddr     = WA'(idx_in_x >> BW);
                        chk_addr_next = WA'(idx_in_x >> BW);
                        low_bit_next  = block_index[BW-1:0];
                        if (bba_pkg::op_t'(operation) == bba_pkg::OP_FIND)
                        begin
                            state_next = bba_pkg::S_SCAN;
                        end
                        else
                        begin
                            state_next = bba_pkg::S_ACCESS;
                        end
                    end
                end
            end

            bba_pkg::S_ACCESS:
            begin
                found_next  = MAX_VAL;
                status_next = bba_pkg::ST_OK;
                done_next   = 1'b1;
                state_next  = bba_pkg::S_IDLE;
                case (op_reg)
                    bba_pkg::OP_CHECK:
                    begin
                        status_next = bit_used ? bba_pkg::ST_OK : bba_pkg::ST_CONFLICT;
                    end

                    bba_pkg::OP_CLAIM:
                    begin
                        if (bit_used)
                        begin
                            status_next = bba_pkg::ST_CONFLICT;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = mem_rdata | bit_mask;
                            cnt_next  = (cnt_reg == '0) ? '0 : cnt_reg - CNT_W'(1);
                            if (idx_x == 32'(hint_reg))
                            begin
                                if (next_x >= bc_x)
                                begin
                                    hint_next = MAX_VAL;
                                end
                                else
                                begin
                                    // Search onward for the new hint. A read of the
                                    // word being written returns stale data, but the
                                    // claimed bit lies below the start bit there.
                                    done_next     = 1'b0;
                                    state_next    = bba_pkg::S_SCAN;
                                    mem_raddr     = WA'(next_x >> BW);
                                    chk_addr_next = WA'(next_x >> BW);
                                    low_bit_next  = next_x[BW-1:0];
                                end
                            end
                        end
                    end

                    bba_pkg::OP_RELEASE:
                    begin
                        if (!bit_used)
                        begin
                            status_next = bba_pkg::ST_CONFLICT;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = mem_rdata & ~bit_mask;
                            if (idx_x < 32'(hint_reg))
                            begin
                                hint_next = CNT_W'(idx_x);
                            end
                            if (cnt_reg < bc_reg)
                            begin
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                    end

                    default:
                    begin
                        status_next = bba_pkg::ST_OK;
                    end
                endcase
            end

            bba_pkg::S_SCAN:
            begin
                if (scan_res.found || (base_x + 32'(WB) >= bc_x))
                begin
                    done_next   = 1'b1;
                    state_next  = bba_pkg::S_IDLE;
                    status_next = bba_pkg::ST_OK;
                    found_next  = MAX_VAL;
                    if (op_reg == bba_pkg::OP_FIND)
                    begin
                        if (scan_res.found)
                        begin
                            found_next = CNT_W'(pos_x);
                        end
                        else
                        begin
                            status_next = bba_pkg::ST_NOFREE;
                        end
                    end
                    else
                    begin
                        hint_next = scan_res.found ? CNT_W'(pos_x) : MAX_VAL;
                    end
                end
                else
                begin
                    // Next word, read issued now and checked next cycle
                    mem_raddr     = chk_addr_reg + WA'(1);
                    chk_addr_next = chk_addr_reg + WA'(1);
                    low_bit_next  = '0;
                end
            end

            default:
            begin
                state_next = bba_pkg::S_IDLE;
            end
        endcase

        // Block count write restarts the map
        if (block_count_wr)
        begin
            bc_next       = bc_sat;
            cnt_next      = bc_sat;
            hint_next     = (bc_sat == '0) ? MAX_VAL : '0;
            state_next    = bba_pkg::S_CLEAR;
            clr_addr_next = '0;
            done_next     = 1'b0;
        end
    end

    // Output ports
    assign cnt_x   = 32'(cnt_reg);
    assign hint_x  = 32'(hint_reg);
    assign found_x = 32'(found_reg);

    assign busy            = (state_reg != bba_pkg::S_IDLE);
    assign done            = done_reg;
    assign status          = status_reg;
    assign found_block     = found_x[bba_pkg::OUT_W-1:0];
    assign free_total      = cnt_x[bba_pkg::OUT_W-1:0];
    assign first_free_hint = hint_x[bba_pkg::OUT_W-1:0];

`ifndef SYNTHESIS
    // Free count never exceeds the configured block count
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= bc_reg)
        else $error("free count above block count");

    // Hint names a block in range or is exhausted
    assert property (@(posedge clk) disable iff (!rst_n)
        (hint_reg == MAX_VAL) || (hint_reg < bc_reg))
        else $error("hint out of range");

    // A result is only presented while the sequencer is back at idle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // Out-of-range index is answered in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !block_count_wr && (idx_in_x >= bc_x))
        |=> (done && (status == bba_pkg::ST_RANGE)))
        else $error("range error not reported");

    // Scan never walks past the bitmap
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bba_pkg::S_SCAN) |-> (32'(chk_addr_reg) < 32'(WORDS)))
        else $error("scan address beyond map");
`endif

endmodule

// File: rtl/bba_map_ram.sv
// Used/free bitmap memory: one write port, one registered read port.
module bba_map_ram #(
    parameter int WORDS = 16,
    parameter int WA    = 4
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [WA-1:0]                  waddr,
    input  logic [bba_pkg::WORD_BITS-1:0]  wdata,
    input  logic [WA-1:0]                  raddr,
    output logic [bba_pkg::WORD_BITS-1:0]  rdata
);

    logic [bba_pkg::WORD_BITS-1:0] mem [WORDS];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port (old data on a same-address write)
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/bba_word_scan.sv
// Finds the lowest free block bit in one bitmap word between a start bit and a limit.
module bba_word_scan (
    input  logic [bba_pkg::WORD_BITS-1:0] word,
    input  logic [bba_pkg::BIT_W-1:0]     low_bit,
    input  logic [bba_pkg::BIT_W:0]       limit,
    output bba_pkg::scan_res_t            res
);

    localparam int BW = bba_pkg::BIT_W;

    // Priority encoder, lowest qualifying bit wins
    always_comb
    begin
        res.found = 1'b0;
        res.pos   = '0;
        for (int j = bba_pkg::WORD_BITS - 1; j >= 0; j--)
        begin
            if (!word[j] && (BW'(j) >= low_bit) && ((BW + 1)'(j) < limit))
            begin
                res.found = 1'b1;
                res.pos   = BW'(j);
            end
        end
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bitmap block allocator: directed table, then random phases.
module tb;
    import bba_pkg::*;

    localparam int NBLK      = MAX_BLOCKS_DEF;
    localparam int CYCLE_CAP = 400000;
    localparam int PHASES    = 9;

    // One expected transaction result
    typedef struct packed {
        status_t          st;
        logic [OUT_W-1:0] found;
        logic [OUT_W-1:0] free;
        logic [OUT_W-1:0] hint;
    } alloc_res_t;

    // One row of the directed table: a register write or an operation
    typedef struct {
        logic             is_cfg;
        logic             typed;
        op_t              op;
        logic [IDX_W-1:0] idx;
        logic [CFG_W-1:0] cfg_val;
        alloc_res_t       want;
    } dir_row_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       operation;
    logic [IDX_W-1:0] block_index;
    logic             block_count_wr;
    logic [CFG_W-1:0] block_count_data;
    logic             done;
    logic [1:0]       status;
    logic [OUT_W-1:0] found_block;
    logic [OUT_W-1:0] free_total;
    logic [OUT_W-1:0] first_free_hint;

    // Predictor state
    bit         blk_used [NBLK];
    int         cfg_blocks;
    int         free_cnt;
    int         hint_blk;

    alloc_res_t pending_results[$];
    dir_row_t   dir_rows[$];
    int         mismatches;

    bitmap_block_allocator_top u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .operation        (operation),
        .block_index      (block_index),
        .block_count_wr   (block_count_wr),
        .block_count_data (block_count_data),
        .done             (done),
        .status           (status),
        .found_block      (found_block),
        .free_total       (free_total),
        .first_free_hint  (first_free_hint)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Lowest free block in [from, cfg_blocks), NBLK if none
    function automatic int first_free_from(input int from);
        for (int i = from; i < cfg_blocks; i++)
        begin
            if (!blk_used[i])
                return i;
        end
        return NBLK;
    endfunction

    // Register write: saturate, clear the map, reload counter and hint
    function automatic void apply_block_count(input int v);
        cfg_blocks = (v > NBLK) ? NBLK : v;
        foreach (blk_used[i])
            blk_used[i] = 1'b0;
        free_cnt = cfg_blocks;
        hint_blk = (cfg_blocks == 0) ? NBLK : 0;
    endfunction

    // Apply one operation to the predictor state and return its result
    function automatic alloc_res_t predict_alloc(input op_t op, input int idx);
        alloc_res_t r;
        int         fnd;
        r.st = ST_OK;
        fnd  = NBLK;
        if (idx >= cfg_blocks)
            r.st = ST_RANGE;
        else
        begin
            case (op)
                OP_CHECK:
                    if (!blk_used[idx])
                        r.st = ST_CONFLICT;
                OP_CLAIM:
                    if (blk_used[idx])
                        r.st = ST_CONFLICT;
                    else
                    begin
                        blk_used[idx] = 1'b1;
                        if (free_cnt > 0)
                            free_cnt--;
                        if (idx == hint_blk)
                            hint_blk = first_free_from(idx + 1);
                    end
                OP_RELEASE:
                    if (!blk_used[idx])
                        r.st = ST_CONFLICT;
                    else
                    begin
                        blk_used[idx] = 1'b0;
                        if (idx < hint_blk)
                            hint_blk = idx;
                        if (free_cnt < cfg_blocks)
                            free_cnt++;
                    end
                default:
                begin
                    fnd = first_free_from(idx);
                    if (fnd >= NBLK)
                        r.st = ST_NOFREE;
                end
            endcase
        end
        r.found = OUT_W'(fnd);
        r.free  = OUT_W'(free_cnt);
        r.hint  = OUT_W'(hint_blk);
        return r;
    endfunction

    // Table builders
    task automatic row_cfg(input int v);
        dir_row_t row;
        row.is_cfg  = 1'b1;
        row.typed   = 1'b0;
        row.op      = OP_CHECK;
        row.idx     = '0;
        row.cfg_val = CFG_W'(v);
        row.want    = '0;
        dir_rows.push_back(row);
    endtask

    task automatic row_op(input op_t op, input int idx);
        dir_row_t row;
        row.is_cfg  = 1'b0;
        row.typed   = 1'b0;
        row.op      = op;
        row.idx     = IDX_W'(idx);
        row.cfg_val = '0;
        row.want    = '0;
        dir_rows.push_back(row);
    endtask

    task automatic row_chk(input op_t op, input int idx, input status_t st,
                           input int found, input int free, input int hint);
        dir_row_t row;
        row.is_cfg     = 1'b0;
        row.typed      = 1'b1;
        row.op         = op;
        row.idx        = IDX_W'(idx);
        row.cfg_val    = '0;
        row.want.st    = st;
        row.want.found = OUT_W'(found);
        row.want.free  = OUT_W'(free);
        row.want.hint  = OUT_W'(hint);
        dir_rows.push_back(row);
    endtask

    // Present one transaction and hold it until accepted
    task automatic issue(input op_t op, input logic [IDX_W-1:0] idx,
                         input logic typed, input alloc_res_t want);
        alloc_res_t pred;
        start       <= 1'b1;
        operation   <= op;
        block_index <= idx;
        do
            @(posedge clk);
        while (busy);
        pred = predict_alloc(op, idx);
        pending_results.push_back(typed ? want : pred);
    endtask

    task automatic idle_gap(input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending until every result is back and the block is idle
    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_block_count(input logic [CFG_W-1:0] v);
        drain();
        block_count_wr   <= 1'b1;
        block_count_data <= v;
        @(posedge clk);
        block_count_wr   <= 1'b0;
        apply_block_count(v);
    endtask

    // Random transaction biased toward valid claims and releases
    task automatic random_item(input int claim_w);
        op_t              op;
        logic [IDX_W-1:0] idx;
        int               r;
        int               s;
        r = $urandom_range(0, 99);
        if (r < 15)
            op = OP_CHECK;
        else if (r < 15 + claim_w)
            op = OP_CLAIM;
        else if (r < 40 + claim_w)
            op = OP_RELEASE;
        else
            op = OP_FIND;
        s = $urandom_range(0, 99);
        if (s < 10 || cfg_blocks == 0)
            idx = IDX_W'($urandom_range(0, NBLK - 1));
        else if (s < 18 && cfg_blocks < NBLK)
            idx = IDX_W'($urandom_range(cfg_blocks, NBLK - 1));
        else if (s < 45 && op != OP_RELEASE && hint_blk < cfg_blocks)
            idx = IDX_W'(hint_blk);
        else
        begin
            idx = IDX_W'($urandom_range(0, cfg_blocks - 1));
            // releases mostly hit a used block
            for (int t = 0; t < 6 && op == OP_RELEASE && !blk_used[idx]; t++)
                idx = IDX_W'($urandom_range(0, cfg_blocks - 1));
        end
        issue(op, idx, 1'b0, '0);
    endtask

    // Stimulus
    initial
    begin
        int cnt;
        int n_items;
        int claim_w;
        int quiet;
        rst_n            <= 1'b0;
        start            <= 1'b0;
        operation        <= OP_CHECK;
        block_index      <= '0;
        block_count_wr   <= 1'b0;
        block_count_data <= '0;
        mismatches        = 0;
        apply_block_count(BC_RESET);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // After reset: full map, all free
        row_chk(OP_CHECK,   0,    ST_CONFLICT, NBLK, 1024, 0);
        row_chk(OP_FIND,    0,    ST_OK,       0,    1024, 0);
        row_chk(OP_FIND,    1023, ST_OK,       1023, 1024, 0);
        row_chk(OP_CLAIM,   0,    ST_OK,       NBLK, 1023, 1);
        row_chk(OP_CLAIM,   0,    ST_CONFLICT, NBLK, 1023, 1);
        row_chk(OP_CHECK,   0,    ST_OK,       NBLK, 1023, 1);
        row_chk(OP_RELEASE, 1023, ST_CONFLICT, NBLK, 1023, 1);
        row_chk(OP_CLAIM,   1023, ST_OK,       NBLK, 1022, 1);
        row_chk(OP_FIND,    1023, ST_NOFREE,   NBLK, 1022, 1);
        row_chk(OP_RELEASE, 0,    ST_OK,       NBLK, 1023, 0);
        row_op(OP_CLAIM, 1);
        row_op(OP_CLAIM, 0);
        row_op(OP_FIND, 0);
        row_op(OP_RELEASE, 1023);
        // No blocks: everything is out of range, hint exhausted
        row_cfg(0);
        row_chk(OP_CHECK,   0,    ST_RANGE,    NBLK, 0, NBLK);
        row_chk(OP_FIND,    1023, ST_RANGE,    NBLK, 0, NBLK);
        row_chk(OP_RELEASE, 0,    ST_RANGE,    NBLK, 0, NBLK);
        // Single block: claim exhausts the hint, release restores it
        row_cfg(1);
        row_chk(OP_CLAIM,   0,    ST_OK,       NBLK, 0, NBLK);
        row_chk(OP_FIND,    0,    ST_NOFREE,   NBLK, 0, NBLK);
        row_chk(OP_CHECK,   1,    ST_RANGE,    NBLK, 0, NBLK);
        row_chk(OP_RELEASE, 0,    ST_OK,       NBLK, 1, 0);
        // Oversized count saturates
        row_cfg(2047);
        row_op(OP_CLAIM, 1023);
        row_op(OP_CHECK, 1023);
        // Top index just past the bound
        row_cfg(1023);
        row_chk(OP_CLAIM,   1023, ST_RANGE,    NBLK, 1023, 0);
        row_op(OP_FIND, 1000);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                write_block_count(dir_rows[i].cfg_val);
            else
            begin
                issue(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].typed, dir_rows[i].want);
                if ($urandom_range(0, 3) == 0)
                    idle_gap($urandom_range(1, 18));
            end
        end

        // Random phases, each under its own block count
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       cnt = 1024;
                1:       cnt = $urandom_range(1, 16);
                2:       cnt = 64;
                3:       cnt = 65;
                4:       cnt = $urandom_range(1025, 2047);
                5:       cnt = $urandom_range(1, 200);
                6:       cnt = 0;
                7:       cnt = $urandom_range(17, 128);
                default: cnt = $urandom_range(1, 64);
            endcase
            write_block_count(CFG_W'(cnt));
            n_items = (cnt == 0) ? 20 : 140;
            claim_w = $urandom_range(30, 55);
            quiet   = (ph == PHASES - 1) || ($urandom_range(0, 4) == 0);
            for (int k = 0; k < n_items; k++)
            begin
                random_item(claim_w);
                if (k == n_items / 2 && (ph == 1 || $urandom_range(0, 1) == 1))
                    drain();
                else if (!quiet && $urandom_range(0, 3) == 0)
                    idle_gap($urandom_range(1, 18));
            end
        end

        drain();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Result checker: every done strobe against the oldest expectation
    always @(posedge clk)
    begin : check_results
        alloc_res_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result at %0t: st=%0d found=%0d free=%0d hint=%0d",
                             $realtime, status, found_block, free_total, first_free_hint);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.st || found_block !== want.found ||
                    free_total !== want.free || first_free_hint !== want.hint)
                begin
                    if (mismatches < 10)
                        $display({"mismatch at %0t: exp st=%0d found=%0d free=%0d hint=%0d",
                                  " got st=%0d found=%0d free=%0d hint=%0d"},
                                 $realtime, want.st, want.found, want.free, want.hint,
                                 status, found_block, free_total, first_free_hint);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        repeat (CYCLE_CAP) @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
